@@ design/text_console_cell_writer_assert.svh @@
// assertion macros for the text console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// property that must hold whenever the block is out of reset
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never be seen while the block is out of reset
`define TCW_ASSERT_NEVER(label, bad, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(bad)) else $error(msg);

`endif

@@ design/tcw_pkg.sv @@
// types and constants shared by the text console cell writer
package tcw_pkg;
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_MOVE  = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] FILL_RESET   = 8'h07;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] char_code;
        logic [7:0] color;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_color;
        logic        scrolled;
        logic        ignored;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  func;
        logic        newline;
        logic        in_range;
        logic [10:0] pos;
        logic [7:0]  char_code;
        logic [7:0]  color;
    } t_cmd;
endpackage

@@ design/tcw_front.sv @@
// front end: accepts items, range-checks and computes linear positions
module tcw_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  tcw_pkg::t_in_item i_in,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output tcw_pkg::t_cmd    o_cmd
);
    import tcw_pkg::*;

    // two-entry command queue
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_cmd;
    logic w_push, w_pop;
    logic [17:0] w_prod;

    always_comb begin
        w_prod = 18'(i_in.row) * 18'(COLS) + 18'(i_in.col);
        w_cmd.func      = i_in.func;
        w_cmd.newline   = (i_in.char_code == NEWLINE_CHAR);
        w_cmd.in_range  = (32'(i_in.row) < ROWS) && (32'(i_in.col) < COLS);
        w_cmd.pos       = w_prod[10:0];
        w_cmd.char_code = i_in.char_code;
        w_cmd.color     = i_in.color;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

@@ design/tcw_back.sv @@
// back end: cell memory, cursor, scroll sequencer and result register
module tcw_back #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  tcw_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_fill_color,
    output logic              o_empty,
    input  logic              i_pop,
    output tcw_pkg::t_out_item o_out,
    output logic              o_busy
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int LAST_ROW = (ROWS - 1) * COLS;
    localparam int AW = $clog2(CELLS);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_SRD   = 6'b001000,
        ST_SWR   = 6'b010000,
        ST_FILL  = 6'b100000
    } t_state;

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;
    t_state r_state, n_state;
    logic [10:0] r_cursor, n_cursor;
    logic [10:0] r_idx, n_idx;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0] w_wdata;
    logic        w_take;
    logic [10:0] w_cur, w_row_start;
    logic        w_slot;

    assign w_slot = !r_ovalid || i_pop;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_slot;
    assign w_take = o_cmd_ready && i_cmd_valid;
    assign o_empty = !r_ovalid;
    assign o_out = r_out;
    assign o_busy = (r_state != ST_IDLE) || i_cmd_valid || r_ovalid;
    assign w_cur = (32'(r_cursor) >= CELLS) ? 11'd0 : r_cursor;

    // start of the row holding the cursor, stepped one row at a time
    always_comb begin
        w_row_start = 11'd0;
        for (int k = 1; k < ROWS; k++) begin
            if (32'(w_cur) >= k * COLS) w_row_start = 11'(k * COLS);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cursor = r_cursor;
        n_idx = r_idx;
        n_ovalid = r_ovalid && !i_pop;
        n_out = r_out;
        w_we = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = 16'h0000;
        w_raddr = r_idx[AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                n_idx = r_idx + 11'd1;
                if (32'(r_idx) == CELLS - 1) begin
                    n_state = ST_IDLE;
                    n_idx = 11'd0;
                end
            end
            ST_IDLE: begin
                w_raddr = i_cmd.pos[AW-1:0];
                if (w_take) begin
                    n_out = '0;
                    n_out.cursor_pos = w_cur;
                    n_cursor = w_cur;
                    if (i_cmd.func == FUNC_PUT) begin
                        if (i_cmd.newline) begin
                            if (32'(w_row_start) == LAST_ROW) begin
                                n_cursor = 11'(LAST_ROW);
                                n_state = ST_SRD;
                                n_idx = 11'(COLS);
                            end else begin
                                n_cursor = w_row_start + 11'(COLS);
                                n_out.cursor_pos = n_cursor;
                                n_ovalid = 1'b1;
                            end
                        end else begin
                            w_we = 1'b1;
                            w_waddr = w_cur[AW-1:0];
                            w_wdata = {i_cmd.color, i_cmd.char_code};
                            if (32'(w_cur) == CELLS - 1) begin
                                n_cursor = 11'(LAST_ROW);
                                n_state = ST_SRD;
                                n_idx = 11'(COLS);
                            end else begin
                                n_cursor = w_cur + 11'd1;
                                n_out.cursor_pos = n_cursor;
                                n_ovalid = 1'b1;
                            end
                        end
                    end else if (!i_cmd.in_range) begin
                        n_out.ignored = 1'b1;
                        n_ovalid = 1'b1;
                    end else if (i_cmd.func == FUNC_WRITE) begin
                        w_we = 1'b1;
                        w_waddr = i_cmd.pos[AW-1:0];
                        w_wdata = {i_cmd.color, i_cmd.char_code};
                        n_ovalid = 1'b1;
                    end else if (i_cmd.func == FUNC_MOVE) begin
                        n_cursor = i_cmd.pos;
                        n_out.cursor_pos = i_cmd.pos;
                        n_ovalid = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_out.read_char = r_rdata[7:0];
                n_out.read_color = r_rdata[15:8];
                n_ovalid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SRD: begin
                // read issued at r_idx, data valid next cycle
                n_state = ST_SWR;
            end
            ST_SWR: begin
                w_we = 1'b1;
                w_waddr = AW'(32'(r_idx) - COLS);
                w_wdata = r_rdata;
                n_idx = r_idx + 11'd1;
                w_raddr = n_idx[AW-1:0];
                if (32'(r_idx) == CELLS - 1) begin
                    n_state = ST_FILL;
                    n_idx = 11'(LAST_ROW);
                end else begin
                    n_state = ST_SWR;
                end
            end
            ST_FILL: begin
                w_we = 1'b1;
                w_wdata = {i_fill_color, BLANK_CHAR};
                n_idx = r_idx + 11'd1;
                if (32'(r_idx) == CELLS - 1 && w_slot) begin
                    n_state = ST_IDLE;
                    n_out.cursor_pos = r_cursor;
                    n_out.scrolled = 1'b1;
                    n_ovalid = 1'b1;
                end else if (32'(r_idx) == CELLS - 1) begin
                    n_idx = r_idx;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cursor <= 11'd0;
            r_idx <= 11'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cursor <= n_cursor;
            r_idx <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end
endmodule

@@ design/text_console_cell_writer.sv @@
// top level of the text console cell writer
// channel | direction | handshake      | payload
// input   | in        | push / full    | t_in_item
// result  | out       | pop / empty    | t_out_item
// config  | in        | valid / ready  | fill colour byte
// plain writes, moves and out-of-range items are answered from the idle state of the back end,
// a read passes through a second state for the registered cell memory port.
// a scroll copies every row but the first up one row through the cell memory, then
// blanks the last row with the fill colour; input stalls until its result.
// after reset a clearing pass over every cell zeroes the memory before
// any item is taken.
module text_console_cell_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tcw_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output tcw_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import tcw_pkg::*;
    `include "text_console_cell_writer_assert.svh"

    logic r_fill_ok;
    logic [7:0] r_fill;
    logic w_cmd_valid, w_cmd_ready, w_busy;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_RESET;
            r_fill_ok <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fill <= i_cfg_data;
            r_fill_ok <= !w_busy;
        end
    end

    tcw_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_in(i_in),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    tcw_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .i_fill_color(r_fill),
        .o_empty(empty), .i_pop(pop), .o_out(o_out), .o_busy(w_busy)
    );

    `TCW_ASSERT(a_cursor_range, (o_out.cursor_pos < 11'(ROWS * COLS)) || empty, "cursor out of range")
    `TCW_ASSERT_NEVER(a_ignored_quiet, !empty && o_out.ignored && (o_out.scrolled || o_out.read_char != 8'd0), "ignored item has side effects")
    `TCW_ASSERT(a_cfg_idle, r_fill_ok || w_busy || !$past(i_cfg_valid), "config written while busy")
endmodule
